### design/assert_macros.svh
// Assertion macros for the checker in gdd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

### design/gdd_pkg.sv
package gdd_pkg;

    localparam int MAX_YEAR_DEF = 9999;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DIST_W = 22;
    localparam int DOY_W  = 9;
    // Signed accumulator; holds any span of 14-bit years with margin.
    localparam int ACC_W  = 25;
    localparam int M100_W = 7;
    localparam int M400_W = 9;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [YEAR_W-1:0] YEARS_400 = YEAR_W'(400);

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);

    typedef struct packed {
        logic load;
        logic reduce;
        logic init;
        logic walk;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic rem_ge_400;
        logic year_done;
    } t_status;

    function automatic logic [DOY_W-1:0] month_len(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] r;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = DOY_W'(31);
                4'd4, 4'd6, 4'd9, 4'd11:                    r = DOY_W'(30);
                4'd2:                                       r = DOY_W'(28);
                default:                                    r = '0;
            endcase
            return r;
        end
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [DOY_W-1:0] r;
        begin
            unique case (m)
                4'd1:    r = DOY_W'(0);
                4'd2:    r = DOY_W'(31);
                4'd3:    r = DOY_W'(59);
                4'd4:    r = DOY_W'(90);
                4'd5:    r = DOY_W'(120);
                4'd6:    r = DOY_W'(151);
                4'd7:    r = DOY_W'(181);
                4'd8:    r = DOY_W'(212);
                4'd9:    r = DOY_W'(243);
                4'd10:   r = DOY_W'(273);
                4'd11:   r = DOY_W'(304);
                4'd12:   r = DOY_W'(334);
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic day_leap(input logic [1:0] m4, input logic [M100_W-1:0] m100,
                                      input logic [M400_W-1:0] m400);
        begin
            return ((m4 == 2'd0) && (m100 != '0)) || (m400 == '0);
        end
    endfunction

    // A day past the end of its month, or a month outside 1..12, gives zero.
    function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                     input logic [MON_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] len;
        logic [DOY_W-1:0] r;
        begin
            r = '0;
            if (m >= MON_JAN && m <= MON_DEC) begin
                len = month_len(m) + ((m == MON_FEB) ? DOY_W'(leap) : DOY_W'(0));
                if (DOY_W'(d) <= len) begin
                    r = cum_days(m) + ((m > MON_FEB) ? DOY_W'(leap) : DOY_W'(0))
                        + DOY_W'(d);
                end
            end
            return r;
        end
    endfunction

endpackage

### design/gregorian_date_distance_core.sv
// Channel  Handshake                  Payload
// input    i_in_valid / o_in_stall    i_first_*, i_second_* (day, month, year)
// output   o_out_valid / i_out_stall  o_day_distance
//
// One request at a time: after a request is accepted, the controller reduces y_lo
// modulo 400, seeds the year counters and walks the years from y_lo to y_hi, y_lo and
// y_hi being the ordered years, and then offers the result.
// The time to a result is set by the year walk, which adds one year per cycle, and by
// the year-modulo-400 reduction that runs before it, one subtraction a cycle.
// Reset is synchronous and active low; it returns the controller to idle.
// The result is held while i_out_stall is high; no new request is taken until
// it has been delivered.
module gregorian_date_distance_core
    import gdd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [DAY_W-1:0]  i_first_day,
    input  logic [MON_W-1:0]  i_first_month,
    input  logic [YEAR_W-1:0] i_first_year,
    input  logic [DAY_W-1:0]  i_second_day,
    input  logic [MON_W-1:0]  i_second_month,
    input  logic [YEAR_W-1:0] i_second_year,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [DIST_W-1:0] o_day_distance
);

    t_cmd    cmd;
    t_status status;

    gdd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    gdd_datapath #(
        .MAX_YEAR (MAX_YEAR)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_day_distance (o_day_distance)
    );

endmodule

### design/gdd_ctrl.sv
module gdd_ctrl
    import gdd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall,
    output logic    o_out_valid
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_WALK   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_REDUCE;
                end
            end
            S_REDUCE: begin
                // Once the remainder is below 400, S_REDUCE seeds the year counters instead of subtracting.
                if (i_status.rem_ge_400) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    o_cmd.init = 1'b1;
                    n_state    = S_WALK;
                end
            end
            S_WALK: begin
                if (i_status.year_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.walk = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);

endmodule

### design/gdd_datapath.sv
module gdd_datapath
    import gdd_pkg::*;
#(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic              i_clk,
    input  logic [DAY_W-1:0]  i_first_day,
    input  logic [MON_W-1:0]  i_first_month,
    input  logic [YEAR_W-1:0] i_first_year,
    input  logic [DAY_W-1:0]  i_second_day,
    input  logic [MON_W-1:0]  i_second_month,
    input  logic [YEAR_W-1:0] i_second_year,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    output logic [DIST_W-1:0] o_day_distance
);

    logic [DAY_W-1:0]  r_d1, r_d2;
    logic [MON_W-1:0]  r_m1, r_m2;
    logic [YEAR_W-1:0] r_y, r_y2, r_rem;
    logic [M100_W-1:0] r_m100;
    logic [M400_W-1:0] r_m400;
    logic signed [ACC_W-1:0] r_dist;
    logic [DIST_W-1:0] r_result;

    logic [YEAR_W-1:0] cy1, cy2;
    logic              swap;
    logic [M400_W-1:0] seed_m400;
    logic [M100_W-1:0] seed_m100;
    logic              seed_leap, cur_leap;
    logic signed [ACC_W-1:0] sum;
    logic [ACC_W-1:0]  mag;
    logic [DIST_W-1:0] sat;

    always_comb begin
        cy1 = (32'(i_first_year) > MAX_YEAR) ? YEAR_W'(MAX_YEAR) : i_first_year;
        cy2 = (32'(i_second_year) > MAX_YEAR) ? YEAR_W'(MAX_YEAR) : i_second_year;
        swap = (cy1 > cy2);
    end

    // The remainder is below 400 here; fold it to the century position.
    always_comb begin
        seed_m400 = M400_W'(r_rem);
        if (seed_m400 >= M400_W'(300)) begin
            seed_m100 = M100_W'(seed_m400 - M400_W'(300));
        end else if (seed_m400 >= M400_W'(200)) begin
            seed_m100 = M100_W'(seed_m400 - M400_W'(200));
        end else if (seed_m400 >= M400_W'(100)) begin
            seed_m100 = M100_W'(seed_m400 - M400_W'(100));
        end else begin
            seed_m100 = M100_W'(seed_m400);
        end
        seed_leap = day_leap(r_y[1:0], seed_m100, seed_m400);
        cur_leap  = day_leap(r_y[1:0], r_m100, r_m400);
    end

    always_comb begin
        sum = r_dist + ACC_W'(day_of_year(r_d2, r_m2, cur_leap));
        mag = (sum < 0) ? ACC_W'(-sum) : ACC_W'(sum);
        sat = (mag > ACC_W'(DIST_MAX)) ? DIST_MAX : mag[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d1  <= swap ? i_second_day   : i_first_day;
            r_m1  <= swap ? i_second_month : i_first_month;
            r_d2  <= swap ? i_first_day    : i_second_day;
            r_m2  <= swap ? i_first_month  : i_second_month;
            r_y   <= swap ? cy2 : cy1;
            r_rem <= swap ? cy2 : cy1;
            r_y2  <= swap ? cy1 : cy2;
        end
        if (i_cmd.reduce) begin
            r_rem <= r_rem - YEARS_400;
        end
        if (i_cmd.init) begin
            r_m400 <= seed_m400;
            r_m100 <= seed_m100;
            r_dist <= -ACC_W'(day_of_year(r_d1, r_m1, seed_leap));
        end
        if (i_cmd.walk) begin
            r_dist <= r_dist + ACC_W'(365) + ACC_W'(cur_leap);
            r_y    <= r_y + YEAR_W'(1);
            r_m100 <= (r_m100 == M100_W'(99))  ? '0 : r_m100 + M100_W'(1);
            r_m400 <= (r_m400 == M400_W'(399)) ? '0 : r_m400 + M400_W'(1);
        end
        if (i_cmd.finish) begin
            r_result <= sat;
        end
    end

    assign o_status.rem_ge_400 = (r_rem >= YEARS_400);
    assign o_status.year_done  = (r_y == r_y2);
    assign o_day_distance      = r_result;

endmodule

### design/gdd_checker.sv
`include "assert_macros.svh"

module gdd_checker
    import gdd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DIST_W-1:0] o_day_distance
);

    // A result is never ready in the cycle right after its request.
    `ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, !o_out_valid)

    // While a result waits, no further request is taken.
    `ASSERT_SAME(a_busy_while_result, i_clk, i_rst_n, o_out_valid, o_in_stall)

    // Once delivered, the result goes away and the block is idle again.
    `ASSERT_NEXT(a_idle_after_result, i_clk, i_rst_n, o_out_valid && !i_out_stall, !o_out_valid && !o_in_stall)

    // A stalled result holds its value.
    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_day_distance))

endmodule

bind gregorian_date_distance_core gdd_checker u_gdd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_day_distance (o_day_distance)
);

### sim/gdd_distance_checker.sv
module gdd_distance_checker
    import gdd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [DAY_W-1:0]  i_first_day,
    input  logic [MON_W-1:0]  i_first_month,
    input  logic [YEAR_W-1:0] i_first_year,
    input  logic [DAY_W-1:0]  i_second_day,
    input  logic [MON_W-1:0]  i_second_month,
    input  logic [YEAR_W-1:0] i_second_year,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [DIST_W-1:0] i_day_distance,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DIST_W-1:0] distance_q[$];
    int                mismatches = 0;
    int                compared = 0;

    function automatic logic leap_year(input int unsigned y);
        return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input logic leap);
        if (m == MON_FEB)
            return 28 + leap;
        case (m)
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    function automatic int unsigned ordinal_day(input int unsigned d, input int unsigned m,
                                                input logic leap);
        int unsigned total = 0;
        if (m < MON_JAN || m > MON_DEC)
            return 0;
        if (d > days_in_month(m, leap))
            return 0;
        for (int unsigned k = MON_JAN; k < m; k++)
            total += days_in_month(k, leap);
        return total + d;
    endfunction

    // Days from the start of year 0 to the start of year y; year 0 is a leap year.
    function automatic longint days_before_year(input int unsigned y);
        if (y == 0)
            return 0;
        return 365 * longint'(y) + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic int unsigned saturate_year(input int unsigned y);
        return (y > MAX_YEAR_DEF) ? MAX_YEAR_DEF : y;
    endfunction

    // Counting both dates from a common origin gives the same figure as walking
    // the years between them, whichever date comes first.
    function automatic logic [DIST_W-1:0] predict_distance(
        input logic [DAY_W-1:0] d1, input logic [MON_W-1:0] m1, input logic [YEAR_W-1:0] y1,
        input logic [DAY_W-1:0] d2, input logic [MON_W-1:0] m2, input logic [YEAR_W-1:0] y2);
        int unsigned ya;
        int unsigned yb;
        longint      pa;
        longint      pb;
        longint      span;
        ya = saturate_year(y1);
        yb = saturate_year(y2);
        pa = days_before_year(ya) + ordinal_day(d1, m1, leap_year(ya));
        pb = days_before_year(yb) + ordinal_day(d2, m2, leap_year(yb));
        span = (pa > pb) ? pa - pb : pb - pa;
        if (span > longint'(DIST_MAX))
            return DIST_MAX;
        return span[DIST_W-1:0];
    endfunction

    always @(posedge i_clk) begin : watch
        logic [DIST_W-1:0] want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (distance_q.size() == 0) begin
                    $error("day_distance: result with no request outstanding, actual %0d",
                           i_day_distance);
                    mismatches++;
                end else begin
                    want = distance_q.pop_front();
                    compared++;
                    if (i_day_distance !== want) begin
                        $error("day_distance mismatch: expected %0d, actual %0d",
                               want, i_day_distance);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                distance_q.push_back(predict_distance(i_first_day, i_first_month,
                                                      i_first_year, i_second_day,
                                                      i_second_month, i_second_year));
        end
        o_pending <= distance_q.size();
        o_fail_count <= mismatches;
        o_checked <= compared;
    end

endmodule

### sim/testbench.sv
module testbench
    import gdd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_REQUESTS = 100;
    localparam int LONG_HOLD = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int YEAR_TOP = (1 << YEAR_W) - 1;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [MON_W-1:0]  month;
        logic [YEAR_W-1:0] year;
    } t_date;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [DAY_W-1:0]  i_first_day = '0;
    logic [MON_W-1:0]  i_first_month = '0;
    logic [YEAR_W-1:0] i_first_year = '0;
    logic [DAY_W-1:0]  i_second_day = '0;
    logic [MON_W-1:0]  i_second_month = '0;
    logic [YEAR_W-1:0] i_second_year = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [DIST_W-1:0] o_day_distance;

    int          fail_count;
    int          pending;
    int          checked;
    int unsigned send_idle_pct = 21;
    int unsigned recv_idle_pct = 68;
    int          hold_asked = 0;
    int          hold_served = 0;
    int          directed_sent = 0;
    int          random_sent = 0;

    gregorian_date_distance_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_day_distance (o_day_distance)
    );

    gdd_distance_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_first_day    (i_first_day),
        .i_first_month  (i_first_month),
        .i_first_year   (i_first_year),
        .i_second_day   (i_second_day),
        .i_second_month (i_second_month),
        .i_second_year  (i_second_year),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_day_distance (o_day_distance),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("gregorian_date_distance_core verification failed");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request from the stimulus.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic t_date make_date(input int unsigned d, input int unsigned m,
                                        input int unsigned y);
        t_date r;
        r.day = DAY_W'(d);
        r.month = MON_W'(m);
        r.year = YEAR_W'(y);
        return r;
    endfunction

    // Mostly real calendar dates; month ends may overrun short months on purpose.
    function automatic t_date random_date();
        t_date r;
        r.year = '0;
        if ($urandom_range(99) < 15) begin
            r.day = DAY_W'($urandom);
            r.month = MON_W'($urandom);
        end else begin
            r.month = MON_W'($urandom_range(MON_DEC, MON_JAN));
            r.day = ($urandom_range(3) == 0) ? DAY_W'($urandom_range(31, 29))
                                             : DAY_W'($urandom_range(28, 1));
        end
        return r;
    endfunction

    // Most pairs sit a few years apart so the year walk stays short.
    task automatic random_pair(output t_date a, output t_date b);
        int unsigned y_lo;
        int unsigned y_hi;
        a = random_date();
        b = random_date();
        if ($urandom_range(19) == 0) begin
            a.year = YEAR_W'($urandom);
            b.year = YEAR_W'($urandom);
        end else begin
            y_lo = $urandom_range(YEAR_TOP);
            y_hi = y_lo + $urandom_range(40);
            if (y_hi > YEAR_TOP)
                y_hi = YEAR_TOP;
            if ($urandom_range(1)) begin
                a.year = YEAR_W'(y_lo);
                b.year = YEAR_W'(y_hi);
            end else begin
                a.year = YEAR_W'(y_hi);
                b.year = YEAR_W'(y_lo);
            end
        end
    endtask

    // Returns at the edge where the request is taken; valid stays high unless a gap follows.
    task automatic send_request(input t_date a, input t_date b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_first_day <= a.day;
        i_first_month <= a.month;
        i_first_year <= a.year;
        i_second_day <= b.day;
        i_second_month <= b.month;
        i_second_year <= b.year;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic directed(input t_date a, input t_date b);
        send_request(a, b);
        directed_sent++;
    endtask

    // The sender goes quiet so the request just taken is not offered again.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        t_date a;
        t_date b;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed(make_date(1, 1, 2000), make_date(1, 1, 2000));
        directed(make_date(1, 1, 0), make_date(31, 12, 9999));
        directed(make_date(31, 12, 9999), make_date(1, 1, 0));
        directed(make_date(31, 12, 2023), make_date(1, 1, 2023));
        directed(make_date(29, 2, 2024), make_date(1, 3, 2024));
        // February 29 in a common year and in a century year that is not leap.
        directed(make_date(29, 2, 2023), make_date(1, 1, 2024));
        directed(make_date(29, 2, 1900), make_date(1, 3, 2000));
        directed(make_date(31, 4, 2001), make_date(15, 6, 2001));
        directed(make_date(31, 11, 500), make_date(31, 1, 499));
        directed(make_date(0, 3, 2024), make_date(1, 1, 2025));
        directed(make_date(0, 1, 1), make_date(31, 12, 400));
        directed(make_date(10, 0, 2020), make_date(10, 5, 2020));
        directed(make_date(1, 15, 1999), make_date(1, 12, 1999));
        directed(make_date(5, 13, 1800), make_date(31, 31, 1799));
        // Years past the upper limit saturate, including the all-ones year.
        directed(make_date(1, 1, YEAR_TOP), make_date(1, 1, 9998));
        directed(make_date(15, 8, 10000), make_date(15, 8, 9999));
        directed(make_date(3, 3, 12000), make_date(4, 4, 14000));
        directed(make_date(29, 2, 0), make_date(1, 1, 1));
        directed(make_date(1, 1, YEAR_TOP), make_date(0, 0, 0));
        directed(make_date(30, 2, 2000), make_date(28, 2, 2100));

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 3) begin
                send_idle_pct = 68;
                recv_idle_pct <= 21;
            end
            if (n == 2 * RANDOM_REQUESTS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct <= 0;
            end
            if (n == 10)
                hold_asked <= hold_asked + 1;
            if (n == RANDOM_REQUESTS / 2)
                wait_for_drain();
            random_pair(a, b);
            send_request(a, b);
            random_sent++;
        end
        i_in_valid <= 1'b0;

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d directed and %0d random date pairs, %0d distances compared,",
                 directed_sent, random_sent, checked);
        $display("across idle and stall mixes, one long result hold-off and one full drain.");
        if (fail_count == 0)
            $display("gregorian_date_distance_core verification clean");
        else
            $display("gregorian_date_distance_core verification failed");
        $finish;
    end

endmodule

### sim.f
+incdir+design
design/gdd_pkg.sv
design/gdd_ctrl.sv
design/gdd_datapath.sv
design/gregorian_date_distance_core.sv
design/gdd_checker.sv
sim/gdd_distance_checker.sv
sim/testbench.sv
